// File: sv/nnau_pkg.sv
// ----------------------------------------------------------------------------
// nnau_pkg: shared types, constants and tables of the activation unit
// Holds the number formats, function codes, register indexes, the
// configuration and sideband structs, and the exp and tanh tables.
// ----------------------------------------------------------------------------
`default_nettype none

package nnau_pkg;

    // data format
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int TABLE_SIZE = 256;
    localparam int EXP_SPAN   = 16;
    localparam int SLOPE_FRAC = 12;
    localparam int SLOPE_W    = 16;

    // internal working format, Q.30
    localparam int WF = 30;

    // table addressing
    localparam int TABLE_BITS = $clog2(TABLE_SIZE);
    localparam int IDX_W      = $clog2(TABLE_SIZE + 1);
    localparam int IDX_SHIFT  = $clog2(EXP_SPAN) + FRAC_BITS - TABLE_BITS;
    localparam int FR_W       = 16;

    // divider layout
    localparam int DIV_STAGES = 6;
    localparam int DIV_STEP   = WF / DIV_STAGES;

    // apb
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    // constants in Q.30
    localparam logic signed [63:0] ONE_W     = 64'sd1 <<< WF;
    localparam logic signed [63:0] ONE_F     = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] ONE_WW    = 64'sd1 <<< (2 * WF);
    localparam logic signed [63:0] K_SELU_L  = 64'sd1128180534;
    localparam logic signed [63:0] K_SELU_LA = 64'sd1887671670;
    localparam logic signed [63:0] K_LEAK    = 64'sd10737418;
    localparam logic signed [63:0] K_RAMP    = 64'sd107374182;

    // saturation bounds
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -(64'sd1 <<< (DATA_WIDTH - 1));

    // rounding shift amounts
    localparam int SHIFT_F  = 0;
    localparam int SHIFT_W  = WF - FRAC_BITS;
    localparam int SHIFT_WW = 2 * WF - FRAC_BITS;
    localparam int SHIFT_FW = WF;
    localparam int SHIFT_S  = SLOPE_FRAC - FRAC_BITS;
    localparam int SHIFT_FS = SLOPE_FRAC;

    // table point spacing in Q.32
    localparam logic [127:0] ROM_STEP = (128'(EXP_SPAN) << 32) / TABLE_SIZE;

    typedef enum logic [3:0] {
        FN_SIGMOID = 4'd0,
        FN_TANH    = 4'd1,
        FN_LINEAR  = 4'd2,
        FN_RAMP    = 4'd3,
        FN_HTANH   = 4'd4,
        FN_RELU    = 4'd5,
        FN_LEAKY   = 4'd6,
        FN_ELU     = 4'd7,
        FN_SELU    = 4'd8,
        FN_PRELU   = 4'd9
    } t_func;

    typedef enum logic [1:0] {
        REG_KIND  = 2'd0,
        REG_DERIV = 2'd1,
        REG_SLOPE = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        SH_F  = 3'd0,
        SH_W  = 3'd1,
        SH_WW = 3'd2,
        SH_FW = 3'd3,
        SH_S  = 3'd4,
        SH_FS = 3'd5
    } t_shift;

    localparam logic [3:0] KIND_RESET = 4'd5;
    localparam logic signed [SLOPE_W-1:0] SLOPE_RESET = 16'sd41;

    typedef logic [WF:0] t_rom_word;
    typedef t_rom_word t_rom [0:TABLE_SIZE];

    typedef struct packed {
        logic [3:0]                 kind;
        logic                       deriv;
        logic signed [SLOPE_W-1:0]  slope;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        t_rom_word                    e;
        t_rom_word                    t;
    } t_side;

    // shift-and-subtract quotient, used only while building the tables
    function automatic logic [127:0] long_div(input logic [127:0] n,
                                              input logic [127:0] d);
        logic [127:0] q;
        logic [127:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 127; b >= 0; b--) begin
            rem = {rem[126:0], n[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // table generation: e^-t by repeated products, tanh from e^-2t
    function automatic t_rom build_rom(input bit want_tanh);
        t_rom               rom;
        logic [127:0]       term;
        logic [127:0]       cur;
        logic [127:0]       f;
        logic [127:0]       e2;
        logic [127:0]       num;
        logic [127:0]       den;
        logic signed [127:0] sum;
        term = 128'd1 << 32;
        sum  = 128'sd1 <<< 32;
        for (int k = 1; k <= 24; k++) begin
            term = long_div((term * ROM_STEP) >> 32, 128'(k));
            if ((k % 2) == 1) sum = sum - $signed(term);
            else sum = sum + $signed(term);
        end
        f   = $unsigned(sum);
        cur = 128'd1 << 32;
        for (int i = 0; i <= TABLE_SIZE; i++) begin
            if (i > 0) cur = (cur * f + (128'd1 << 31)) >> 32;
            if (!want_tanh) begin
                rom[i] = t_rom_word'((cur + 128'd2) >> 2);
            end else if (i == 0) begin
                rom[i] = '0;
            end else begin
                e2  = (cur * cur + (128'd1 << 31)) >> 32;
                num = ((128'd1 << 32) - e2) << 30;
                den = (128'd1 << 32) + e2;
                rom[i] = t_rom_word'(long_div(num + (den >> 1), den));
            end
        end
        return rom;
    endfunction

    localparam t_rom EXP_ROM  = build_rom(1'b0);
    localparam t_rom TANH_ROM = build_rom(1'b1);

endpackage

`default_nettype wire

// File: sv/nnau_cfg.sv
// ----------------------------------------------------------------------------
// nnau_cfg: configuration registers
// APB-style register bank for function select, derivative mode and slope.
// ----------------------------------------------------------------------------
`default_nettype none

module nnau_cfg import nnau_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [3:0]                r_kind;
    logic                      r_deriv;
    logic signed [SLOPE_W-1:0] r_slope;
    logic                      w_wr;
    t_reg_idx                  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_RESET;
            r_deriv <= 1'b0;
            r_slope <= SLOPE_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_KIND:  r_kind  <= pwdata[3:0];
                REG_DERIV: r_deriv <= pwdata[0];
                REG_SLOPE: r_slope <= pwdata[SLOPE_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_KIND:  prdata = APB_DW'(r_kind);
            REG_DERIV: prdata = APB_DW'(r_deriv);
            REG_SLOPE: prdata = APB_DW'($unsigned(r_slope));
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = '{kind: r_kind, deriv: r_deriv, slope: r_slope};

endmodule

`default_nettype wire

// File: sv/nnau_lookup.sv
// ----------------------------------------------------------------------------
// nnau_lookup: table lookup with linear interpolation
// Four stages: address, table read, slope multiply, round and add.
// ----------------------------------------------------------------------------
`default_nettype none

module nnau_lookup import nnau_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_adv,
    input  wire logic                         i_valid,
    input  wire logic signed [DATA_WIDTH-1:0] i_x,
    output logic                              o_valid,
    output t_side                             o_side
);

    // stage 1: address
    logic                         r_v1;
    logic signed [DATA_WIDTH-1:0] r_x1;
    logic [IDX_W-1:0]             r_idx0;
    logic [IDX_W-1:0]             r_idx1;
    logic [FR_W-1:0]              r_fr1;
    logic [DATA_WIDTH-1:0]        w_ax;
    logic [DATA_WIDTH-1:0]        w_full;
    logic                         w_beyond;
    logic [IDX_W-1:0]             n_idx0;
    logic [IDX_W-1:0]             n_idx1;
    logic [FR_W-1:0]              n_fr;

    // stage 2: table words
    logic                         r_v2;
    logic signed [DATA_WIDTH-1:0] r_x2;
    logic [FR_W-1:0]              r_fr2;
    t_rom_word                    r_e0;
    t_rom_word                    r_e1;
    t_rom_word                    r_t0;
    t_rom_word                    r_t1;

    // stage 3: slope products
    logic                         r_v3;
    logic signed [DATA_WIDTH-1:0] r_x3;
    t_rom_word                    r_e0b;
    t_rom_word                    r_t0b;
    logic signed [WF+FR_W+2:0]    r_pe;
    logic signed [WF+FR_W+2:0]    r_pt;
    logic signed [WF+1:0]         w_de;
    logic signed [WF+1:0]         w_dt;

    // stage 4: outputs
    logic                         r_v4;
    t_side                        r_side;

    function automatic logic signed [WF+2:0] round16(
        input logic signed [WF+FR_W+2:0] p
    );
        logic [WF+FR_W+2:0] mag;
        logic [WF+FR_W+2:0] rnd;
        mag = p[WF+FR_W+2] ? $unsigned(-p) : $unsigned(p);
        rnd = (mag + (WF+FR_W+3)'(1 << 15)) >> 16;
        return p[WF+FR_W+2] ? -$signed((WF+3)'(rnd)) : $signed((WF+3)'(rnd));
    endfunction

    // address and fraction from |x|
    always_comb begin
        w_ax     = i_x[DATA_WIDTH-1] ? $unsigned(-i_x) : $unsigned(i_x);
        w_full   = w_ax >> IDX_SHIFT;
        w_beyond = 32'(w_full) >= TABLE_SIZE;
        n_idx0   = w_beyond ? IDX_W'(TABLE_SIZE) : w_full[IDX_W-1:0];
        n_idx1   = w_beyond ? n_idx0 : n_idx0 + IDX_W'(1);
        n_fr     = w_beyond ? '0
                 : FR_W'({w_ax[IDX_SHIFT-1:0], {(FR_W-IDX_SHIFT){1'b0}}});
    end

    assign w_de = $signed({1'b0, r_e1}) - $signed({1'b0, r_e0});
    assign w_dt = $signed({1'b0, r_t1}) - $signed({1'b0, r_t0});

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x1   <= i_x;
            r_idx0 <= n_idx0;
            r_idx1 <= n_idx1;
            r_fr1  <= n_fr;

            r_x2   <= r_x1;
            r_fr2  <= r_fr1;
            r_e0   <= EXP_ROM[r_idx0];
            r_e1   <= EXP_ROM[r_idx1];
            r_t0   <= TANH_ROM[r_idx0];
            r_t1   <= TANH_ROM[r_idx1];

            r_x3   <= r_x2;
            r_e0b  <= r_e0;
            r_t0b  <= r_t0;
            r_pe   <= (WF+FR_W+3)'(w_de * $signed({1'b0, r_fr2}));
            r_pt   <= (WF+FR_W+3)'(w_dt * $signed({1'b0, r_fr2}));

            r_side.x <= r_x3;
            r_side.e <= t_rom_word'($signed({2'b0, r_e0b}) + round16(r_pe));
            r_side.t <= t_rom_word'($signed({2'b0, r_t0b}) + round16(r_pt));
        end
    end

    assign o_valid = r_v4;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// File: sv/nnau_div.sv
// ----------------------------------------------------------------------------
// nnau_div: pipelined restoring divider for the logistic value
// Computes round(2^60 / (2^30 + e)), a few quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module nnau_div import nnau_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  wire logic i_valid,
    input  t_side     i_side,
    output logic      o_valid,
    output t_side     o_side,
    output logic [WF-1:0] o_quot
);

    logic          r_v    [DIV_STAGES];
    t_side         r_side [DIV_STAGES];
    logic [31:0]   r_rem  [DIV_STAGES];
    logic [31:0]   r_d    [DIV_STAGES];
    logic [WF-1:0] r_q    [DIV_STAGES];

    logic [31:0]   s_rem  [DIV_STAGES];
    logic [31:0]   s_d    [DIV_STAGES];
    logic [WF-1:0] s_q    [DIV_STAGES];
    logic [31:0]   n_rem  [DIV_STAGES];
    logic [WF-1:0] n_q    [DIV_STAGES];
    logic [31:0]   w_d0;

    // divisor 2^30 + e, numerator 2^60 + divisor/2
    assign w_d0 = 32'(ONE_W) + 32'(i_side.e);

    // stage inputs
    always_comb begin
        s_rem[0] = 32'(ONE_W) + 32'(w_d0[31]);
        s_d[0]   = w_d0;
        s_q[0]   = '0;
        for (int s = 1; s < DIV_STAGES; s++) begin
            s_rem[s] = r_rem[s-1];
            s_d[s]   = r_d[s-1];
            s_q[s]   = r_q[s-1];
        end
    end

    // quotient bits for each stage, low numerator bits are divisor/2
    always_comb begin
        logic [31:0]   rem;
        logic [WF-1:0] q;
        logic [WF-1:0] nlo;
        int            b;
        for (int s = 0; s < DIV_STAGES; s++) begin
            rem = s_rem[s];
            q   = s_q[s];
            nlo = s_d[s][WF:1];
            for (int j = 0; j < DIV_STEP; j++) begin
                b   = WF - 1 - s * DIV_STEP - j;
                rem = {rem[30:0], nlo[b]};
                if (rem >= s_d[s]) begin
                    rem  = rem - s_d[s];
                    q[b] = 1'b1;
                end
            end
            n_rem[s] = rem;
            n_q[s]   = q;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) r_v[s] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < DIV_STAGES; s++) r_v[s] <= r_v[s-1];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0] <= i_side;
            for (int s = 1; s < DIV_STAGES; s++) r_side[s] <= r_side[s-1];
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_d[s]   <= s_d[s];
                r_q[s]   <= n_q[s];
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];
    assign o_quot  = r_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: sv/nnau_post.sv
// ----------------------------------------------------------------------------
// nnau_post: function select, product, rounding and saturation
// Each function is written as addend + a*b at a known scale, then
// rounded to the output format and clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module nnau_post import nnau_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_adv,
    input  t_cfg                         i_cfg,
    input  wire logic                    i_valid,
    input  t_side                        i_side,
    input  wire logic [WF-1:0]           i_quot,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_result,
    output logic                         o_clipped
);

    // stage 1: operand select
    logic               r_v1;
    logic signed [63:0] r_add1;
    logic signed [31:0] r_ma;
    logic signed [31:0] r_mb;
    t_shift             r_sh1;
    logic signed [63:0] n_add;
    logic signed [31:0] n_ma;
    logic signed [31:0] n_mb;
    t_shift             n_sh;

    // stage 2: product
    logic               r_v2;
    logic signed [63:0] r_add2;
    logic signed [63:0] r_prod;
    t_shift             r_sh2;

    // stage 3: sum
    logic               r_v3;
    logic signed [63:0] r_sum;
    t_shift             r_sh3;

    // stage 4: output register
    logic                         r_v4;
    logic signed [DATA_WIDTH-1:0] r_res;
    logic                         r_clip;

    logic signed [63:0] w_x;
    logic signed [63:0] w_e;
    logic signed [63:0] w_ts;
    logic signed [63:0] w_sp;
    logic signed [63:0] w_slope;
    logic               w_neg;
    logic               w_pos;

    logic [5:0]         w_amt;
    logic [63:0]        w_mag;
    logic [63:0]        w_half;
    logic [63:0]        w_rnd;
    logic signed [63:0] w_r;

    assign w_x     = 64'(i_side.x);
    assign w_e     = $signed(64'(i_side.e));
    assign w_sp    = $signed(64'(i_quot));
    assign w_slope = 64'(i_cfg.slope);
    assign w_neg   = i_side.x[DATA_WIDTH-1];
    assign w_pos   = !w_neg && (i_side.x != '0);
    assign w_ts    = w_neg ? -$signed(64'(i_side.t)) : $signed(64'(i_side.t));

    // per-function operands
    always_comb begin
        n_add = '0;
        n_ma  = '0;
        n_mb  = '0;
        n_sh  = SH_F;
        case (t_func'(i_cfg.kind))
            FN_SIGMOID: begin
                if (i_cfg.deriv) begin
                    n_ma = 32'(w_sp);
                    n_mb = 32'(ONE_W - w_sp);
                    n_sh = SH_WW;
                end else begin
                    n_add = w_neg ? ONE_W - w_sp : w_sp;
                    n_sh  = SH_W;
                end
            end
            FN_TANH: begin
                if (i_cfg.deriv) begin
                    n_add = ONE_WW;
                    n_ma  = 32'(w_ts);
                    n_mb  = 32'(-w_ts);
                    n_sh  = SH_WW;
                end else begin
                    n_add = w_ts;
                    n_sh  = SH_W;
                end
            end
            FN_LINEAR: begin
                n_add = i_cfg.deriv ? ONE_F : w_x;
            end
            FN_RAMP: begin
                if (i_cfg.deriv) begin
                    n_add = (w_pos ? ONE_W : 64'sd0) + K_RAMP;
                    n_sh  = SH_W;
                end else begin
                    n_ma = 32'(w_x);
                    n_mb = 32'((w_pos ? ONE_W : 64'sd0) + K_RAMP);
                    n_sh = SH_FW;
                end
            end
            FN_HTANH: begin
                if (i_cfg.deriv) n_add = (w_x > -ONE_F && w_x < ONE_F) ? ONE_F : 64'sd0;
                else if (w_x < -ONE_F) n_add = -ONE_F;
                else if (w_x > ONE_F) n_add = ONE_F;
                else n_add = w_x;
            end
            FN_RELU: begin
                if (i_cfg.deriv) n_add = w_neg ? 64'sd0 : ONE_F;
                else n_add = w_pos ? w_x : 64'sd0;
            end
            FN_LEAKY: begin
                if (i_cfg.deriv) begin
                    n_add = w_neg ? K_LEAK : ONE_W;
                    n_sh  = SH_W;
                end else begin
                    n_ma = 32'(w_x);
                    n_mb = 32'(w_neg ? K_LEAK : ONE_W);
                    n_sh = SH_FW;
                end
            end
            FN_ELU: begin
                if (w_pos) begin
                    n_add = i_cfg.deriv ? ONE_F : w_x;
                end else begin
                    n_add = i_cfg.deriv ? w_e : w_e - ONE_W;
                    n_sh  = SH_W;
                end
            end
            FN_SELU: begin
                if (w_pos && i_cfg.deriv) begin
                    n_add = K_SELU_L;
                    n_sh  = SH_W;
                end else if (w_pos) begin
                    n_ma = 32'(w_x);
                    n_mb = 32'(K_SELU_L);
                    n_sh = SH_FW;
                end else begin
                    n_ma = 32'(K_SELU_LA);
                    n_mb = 32'(i_cfg.deriv ? w_e : w_e - ONE_W);
                    n_sh = SH_WW;
                end
            end
            FN_PRELU: begin
                if (!w_neg) begin
                    n_add = i_cfg.deriv ? ONE_F : w_x;
                end else if (i_cfg.deriv) begin
                    n_add = w_slope;
                    n_sh  = SH_S;
                end else begin
                    n_ma = 32'(w_x);
                    n_mb = 32'(w_slope);
                    n_sh = SH_FS;
                end
            end
            default: ;
        endcase
    end

    // round to nearest, ties away from zero, then clamp
    always_comb begin
        case (r_sh3)
            SH_W:    w_amt = 6'(SHIFT_W);
            SH_WW:   w_amt = 6'(SHIFT_WW);
            SH_FW:   w_amt = 6'(SHIFT_FW);
            SH_S:    w_amt = 6'(SHIFT_S);
            SH_FS:   w_amt = 6'(SHIFT_FS);
            default: w_amt = 6'(SHIFT_F);
        endcase
        w_mag  = r_sum[63] ? $unsigned(-r_sum) : $unsigned(r_sum);
        w_half = (w_amt == '0) ? 64'd0 : (64'd1 << (w_amt - 6'd1));
        w_rnd  = (w_mag + w_half) >> w_amt;
        w_r    = r_sum[63] ? -$signed(w_rnd) : $signed(w_rnd);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_add1 <= n_add;
            r_ma   <= n_ma;
            r_mb   <= n_mb;
            r_sh1  <= n_sh;

            r_add2 <= r_add1;
            r_prod <= r_ma * r_mb;
            r_sh2  <= r_sh1;

            r_sum  <= r_add2 + r_prod;
            r_sh3  <= r_sh2;

            if (w_r > SAT_HI) begin
                r_res  <= DATA_WIDTH'(SAT_HI);
                r_clip <= 1'b1;
            end else if (w_r < SAT_LO) begin
                r_res  <= DATA_WIDTH'(SAT_LO);
                r_clip <= 1'b1;
            end else begin
                r_res  <= DATA_WIDTH'(w_r);
                r_clip <= 1'b0;
            end
        end
    end

    assign o_valid   = r_v4;
    assign o_result  = r_res;
    assign o_clipped = r_clip;

endmodule

`default_nettype wire

// File: sv/nn_activation_unit.sv
// ----------------------------------------------------------------------------
// nn_activation_unit: activation function unit, Q3.12 in and out
// Input channel i_valid/o_ready carries one sample per item; output
// channel o_valid/i_ready carries the result and its saturation flag.
// The APB port selects the function, derivative mode and prelu slope;
// write it only while no item is in flight.
// An item passes from the input accept edge to o_valid through
// 14 register stages: 4 of table lookup and interpolation, 6 of
// pipelined division (5 quotient bits a stage), 4 of select, multiply,
// add and round/saturate.
// Throughput is one item per cycle; every stage can hold an item.
// When the receiver holds i_ready low with a result waiting, the whole
// pipeline freezes and o_ready drops in the same cycle; nothing is lost.
// Reset clears all valid bits and loads the register defaults
// (relu, value mode, slope 41).
// ----------------------------------------------------------------------------
`default_nettype none

module nn_activation_unit import nnau_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [DATA_WIDTH-1:0] i_sample_in,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0]      o_result_out,
    output logic                              o_clipped,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [APB_AW-1:0]            paddr,
    input  wire logic [APB_DW-1:0]            pwdata,
    output logic      [APB_DW-1:0]            prdata,
    output logic                              pready
);

    t_cfg          w_cfg;
    logic          w_adv;
    logic          w_lk_valid;
    t_side         w_lk_side;
    logic          w_dv_valid;
    t_side         w_dv_side;
    logic [WF-1:0] w_quot;

    // pipeline moves unless a finished item is stuck at the output
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    nnau_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    nnau_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_x     (i_sample_in),
        .o_valid (w_lk_valid),
        .o_side  (w_lk_side)
    );

    nnau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_lk_valid),
        .i_side  (w_lk_side),
        .o_valid (w_dv_valid),
        .o_side  (w_dv_side),
        .o_quot  (w_quot)
    );

    nnau_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_cfg     (w_cfg),
        .i_valid   (w_dv_valid),
        .i_side    (w_dv_side),
        .i_quot    (w_quot),
        .o_valid   (o_valid),
        .o_result  (o_result_out),
        .o_clipped (o_clipped)
    );

endmodule

`default_nettype wire

// File: sv/nnau_checker.sv
// ----------------------------------------------------------------------------
// nnau_checker: port-level checks for the activation unit
// Watches the handshakes and the saturation flag at the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nnau_checker import nnau_pkg::*; (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_ready,
    input wire logic                         o_valid,
    input wire logic                         i_ready,
    input wire logic signed [DATA_WIDTH-1:0] o_result_out,
    input wire logic                         o_clipped
);

    // ready follows the output stage
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");

    // a stalled item is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_out) && $stable(o_clipped))
        else $error("stalled item changed");

    // a clipped item sits at a range limit
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |->
            (o_result_out == DATA_WIDTH'(SAT_HI)) || (o_result_out == DATA_WIDTH'(SAT_LO)))
        else $error("clipped item not saturated");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind nn_activation_unit nnau_checker u_nnau_checker (.*);

`default_nettype wire
